/* rtl/nixie_pkg.sv */
// ----------------------------------------------------------------------------
// Nixie scan driver package
// Shared constants, types and digit helpers for the nixie scan driver.
// ----------------------------------------------------------------------------
package nixie_pkg;

    // Default configuration of the top level.
    localparam int TUBE_COUNT_DEF  = 6;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Bit positions inside the drive word.
    localparam logic [4:0] ANODE_TOP   = 5'd31;
    localparam logic [4:0] CATHODE_TOP = 5'd25;
    localparam int         DP_BIT      = 15;
    localparam int         SEP_A_HI    = 14;
    localparam int         SEP_A_LO    = 13;
    localparam int         SEP_B_HI    = 12;
    localparam int         SEP_B_LO    = 11;

    // Tube that carries the separator bits.
    localparam logic [2:0] SEP_TUBE = 3'd5;

    // Widths of the packed input item and of the drive word.
    localparam int IN_DATA_W = 48;
    localparam int IN_USER_W = 2;
    localparam int WORD_W    = 32;

    // One drive word handed from the front to the queue.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } t_push;

    // Queue status seen by both neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Decimal digit of a 7-bit value: units when sel_tens is low, otherwise
    // the tens digit taken modulo ten. The tens come from a reciprocal
    // multiply (205/2048), which is exact for every 7-bit value.
    function automatic logic [3:0] pick_digit(input logic [6:0] value,
                                              input logic       sel_tens);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  units;
        prod     = 15'(value) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = 7'(tens) * 7'd10;
        units    = value - tens_x10;
        if (sel_tens) begin
            pick_digit = (tens >= 4'd10) ? (tens - 4'd10) : tens;
        end else begin
            pick_digit = units[3:0];
        end
    endfunction

endpackage

/* rtl/nixie_mux_scan_driver_core.sv */
// ----------------------------------------------------------------------------
// Nixie multiplexed scan driver core
// Path: a lit tick's drive word is written into the queue when the tick is
// accepted and then loaded into the output register; its blanking word (tlast
// high) is loaded into the output register once the drive word is taken.
// Throughput: one tick per cycle while the queue has room; each lit tick holds
// the single output register for its drive word and then its blanking word.
// Reset (i_rst_n low, synchronous) clears the tick counter, the tube index,
// the queue and the valid and last flags of the output register.
// ----------------------------------------------------------------------------
module nixie_mux_scan_driver_core #(
    parameter int TUBE_COUNT  = nixie_pkg::TUBE_COUNT_DEF,
    parameter int QUEUE_DEPTH = nixie_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Slave side: one scan tick per item.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata, from bit 0: brightness[7:0], first_pair[14:8],
    // second_pair[21:15], third_pair[28:22], digit_enable[34:29],
    // dot_mask[42:35], zero fill [47:43].
    input  logic [nixie_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser, from bit 0: time_mode[0], date_edit[1].
    input  logic [nixie_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // Master side: drive words and blanking words.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: drive_word[31:0].
    output logic [nixie_pkg::WORD_W-1:0]     m_axis_tdata,
    // tlast: last_of_tick, high on the blanking word.
    output logic                             m_axis_tlast
);

    // The front end decides per tick whether the scan advances (PWM compare
    // of the incremented counter against brightness) and, if so, builds the
    // drive word for the current tube. Dark ticks are absorbed at once.
    // Lit ticks leave one word in the queue; the back end turns each word
    // into the drive word followed by an all-zero blanking word.

    nixie_pkg::t_push              push;
    nixie_pkg::t_qstat             qstat;
    logic [nixie_pkg::WORD_W-1:0]  head;
    logic                          pop;

    nixie_front #(
        .TUBE_COUNT (TUBE_COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .i_brightness   (s_axis_tdata[7:0]),
        .i_first_pair   (s_axis_tdata[14:8]),
        .i_second_pair  (s_axis_tdata[21:15]),
        .i_third_pair   (s_axis_tdata[28:22]),
        .i_digit_enable (s_axis_tdata[34:29]),
        .i_dot_mask     (s_axis_tdata[42:35]),
        .i_time_mode    (s_axis_tuser[0]),
        .i_date_edit    (s_axis_tuser[1]),
        .i_qstat        (qstat),
        .o_ready        (s_axis_tready),
        .o_push         (push)
    );

    // The queue lets the front keep taking ticks while the sink stalls.
    nixie_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    nixie_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_word  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

/* rtl/nixie_front.sv */
// ----------------------------------------------------------------------------
// Nixie scan front end
// Accepts scan ticks, runs the PWM counter and the tube scan, and builds the
// drive word of every lit tick.
// ----------------------------------------------------------------------------
module nixie_front #(
    parameter int TUBE_COUNT = nixie_pkg::TUBE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_brightness,
    input  logic [6:0]            i_first_pair,
    input  logic [6:0]            i_second_pair,
    input  logic [6:0]            i_third_pair,
    input  logic [5:0]            i_digit_enable,
    input  logic [7:0]            i_dot_mask,
    input  logic                  i_time_mode,
    input  logic                  i_date_edit,
    input  nixie_pkg::t_qstat     i_qstat,
    output logic                  o_ready,
    output nixie_pkg::t_push      o_push
);

    localparam logic [2:0] LAST_TUBE = 3'(TUBE_COUNT - 1);

    logic [7:0]  r_tick;
    logic [7:0]  n_tick;
    logic [2:0]  r_tube;
    logic [2:0]  n_tube;
    logic        accept;
    logic        lit;
    logic [7:0]  dots;
    logic [6:0]  pair;
    logic [3:0]  digit;
    logic [31:0] word;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;
    assign n_tick  = r_tick + 8'd1;
    assign lit     = n_tick < i_brightness;

    always_comb begin
        dots = i_dot_mask;
        if (i_time_mode) begin
            dots[7:6] = {2{i_third_pair[0]}};
        end
        unique case (r_tube) inside
            3'd0, 3'd1: pair = i_third_pair;
            3'd2, 3'd3: pair = i_second_pair;
            default:    pair = i_first_pair;
        endcase
        digit = nixie_pkg::pick_digit(pair, r_tube[0]);

        word = '0;
        if (r_tube == nixie_pkg::SEP_TUBE) begin
            word[nixie_pkg::SEP_A_HI] = dots[6];
            word[nixie_pkg::SEP_A_LO] = dots[6];
            word[nixie_pkg::SEP_B_HI] = dots[7];
            word[nixie_pkg::SEP_B_LO] = dots[7];
        end
        if (i_digit_enable[r_tube]) begin
            word[nixie_pkg::ANODE_TOP - 5'(r_tube)] = 1'b1;
            word[nixie_pkg::CATHODE_TOP - 5'(digit)] = 1'b1;
        end
        word[nixie_pkg::DP_BIT] = dots[r_tube];
        if (r_tube == nixie_pkg::SEP_TUBE && i_date_edit) begin
            word[nixie_pkg::SEP_A_LO] = 1'b0;
            word[nixie_pkg::SEP_B_LO] = 1'b0;
        end
    end

    assign n_tube = (r_tube >= LAST_TUBE) ? 3'd0 : (r_tube + 3'd1);

    assign o_push.valid = accept && lit;
    assign o_push.word  = word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_tube <= '0;
        end else if (accept) begin
            r_tick <= n_tick;
            if (lit) begin
                r_tube <= n_tube;
            end
        end
    end

endmodule

/* rtl/nixie_queue.sv */
// ----------------------------------------------------------------------------
// Nixie drive word queue
// Small first-in first-out store of drive words between front and back.
// ----------------------------------------------------------------------------
module nixie_queue #(
    parameter int DEPTH = nixie_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nixie_pkg::t_push              i_push,
    input  logic                          i_pop,
    output logic [nixie_pkg::WORD_W-1:0]  o_head,
    output nixie_pkg::t_qstat             o_qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [nixie_pkg::WORD_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_qstat.full  = (r_count == CNT_W'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign do_push       = i_push.valid && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr_ptr] <= i_push.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/nixie_back.sv */
// ----------------------------------------------------------------------------
// Nixie scan back end
// Sends each queued drive word followed by its blanking word.
// ----------------------------------------------------------------------------
module nixie_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [nixie_pkg::WORD_W-1:0]  i_head,
    input  nixie_pkg::t_qstat             i_qstat,
    output logic                          o_pop,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [nixie_pkg::WORD_W-1:0]  o_word,
    output logic                          o_last
);

    logic                          r_valid;
    logic [nixie_pkg::WORD_W-1:0]  r_word;
    logic                          r_last;
    logic                          load;
    logic                          send_blank;

    // The output register may change when it is empty or being taken.
    assign load       = !r_valid || i_ready;
    // A drive word just shown is always followed by its blanking word.
    assign send_blank = r_valid && !r_last;
    assign o_pop      = load && !send_blank && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else if (load) begin
            if (send_blank) begin
                r_valid <= 1'b1;
                r_last  <= 1'b1;
            end else begin
                r_valid <= !i_qstat.empty;
                r_last  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= send_blank ? '0 : i_head;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_last  = r_last;

endmodule

/* tb/nixie_scan_checker.sv */
// ----------------------------------------------------------------------------
// Nixie scan driver checker
// Watches both stream channels of the scan driver. Every accepted scan tick is
// run through a predictor of the tick counter, the PWM compare and the tube
// sequencer; the drive words it yields are queued and compared, field by field,
// with the items that leave the block.
// ----------------------------------------------------------------------------
module nixie_scan_checker #(
    parameter int TUBE_COUNT = nixie_pkg::TUBE_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    // brightness[7:0], first_pair[14:8], second_pair[21:15], third_pair[28:22],
    // digit_enable[34:29], dot_mask[42:35], zero fill [47:43].
    input  logic [nixie_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // time_mode[0], date_edit[1].
    input  logic [nixie_pkg::IN_USER_W-1:0] i_s_axis_tuser,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // drive_word[31:0].
    input  logic [nixie_pkg::WORD_W-1:0]    i_m_axis_tdata,
    input  logic                            i_m_axis_tlast,
    output int                              o_fail_count,
    output int                              o_words_due,
    output int                              o_words_checked
);

    typedef struct packed {
        logic [nixie_pkg::WORD_W-1:0] word;
        logic                         last;
    } t_drive_item;

    t_drive_item words_due[$];
    logic [7:0]  tick_cnt;
    logic [2:0]  tube_idx;
    int          fail_cnt    = 0;
    int          checked_cnt = 0;

    // Decimal digit shown on a tube; tens are reduced modulo ten so that
    // values above 99 still select a single cathode.
    function automatic int tube_digit(input int tube, input int p1, input int p2,
                                      input int p3);
        case (tube)
            0:       return p3 % 10;
            1:       return (p3 / 10) % 10;
            2:       return p2 % 10;
            3:       return (p2 / 10) % 10;
            4:       return p1 % 10;
            default: return (p1 / 10) % 10;
        endcase
    endfunction

    // Advances the scan state by one tick and queues the words it yields.
    function automatic void predict_tick(input logic [nixie_pkg::IN_DATA_W-1:0] data,
                                         input logic [nixie_pkg::IN_USER_W-1:0] user);
        int                           bri;
        int                           p1;
        int                           p2;
        int                           p3;
        int                           en;
        int                           dots;
        int                           tube;
        logic [nixie_pkg::WORD_W-1:0] word;
        bri  = int'(data[7:0]);
        p1   = int'(data[14:8]);
        p2   = int'(data[21:15]);
        p3   = int'(data[28:22]);
        en   = int'(data[34:29]);
        dots = int'(data[42:35]);
        tick_cnt = tick_cnt + 8'd1;
        if (int'(tick_cnt) >= bri) begin
            return;
        end
        if (user[0]) begin
            if (p3 % 2 == 1) begin
                dots = dots | 'hC0;
            end else begin
                dots = dots & 'h3F;
            end
        end
        tube = int'(tube_idx);
        if (tube >= TUBE_COUNT || tube > 5) begin
            tube = 0;
        end
        word = '0;
        if (tube == int'(nixie_pkg::SEP_TUBE)) begin
            if (dots & 'h40) begin
                word[nixie_pkg::SEP_A_HI] = 1'b1;
                word[nixie_pkg::SEP_A_LO] = 1'b1;
            end
            if (dots & 'h80) begin
                word[nixie_pkg::SEP_B_HI] = 1'b1;
                word[nixie_pkg::SEP_B_LO] = 1'b1;
            end
        end
        if ((en >> tube) & 1) begin
            word[int'(nixie_pkg::ANODE_TOP) - tube] = 1'b1;
            word[int'(nixie_pkg::CATHODE_TOP) - tube_digit(tube, p1, p2, p3)] = 1'b1;
        end
        if ((dots >> tube) & 1) begin
            word[nixie_pkg::DP_BIT] = 1'b1;
        end
        if (tube == int'(nixie_pkg::SEP_TUBE) && user[1]) begin
            word[nixie_pkg::SEP_A_LO] = 1'b0;
            word[nixie_pkg::SEP_B_LO] = 1'b0;
        end
        tube_idx = (tube + 1 >= TUBE_COUNT) ? 3'd0 : 3'(tube + 1);
        words_due.push_back('{word: word, last: 1'b0});
        words_due.push_back('{word: '0, last: 1'b1});
    endfunction

    always @(posedge i_clk) begin
        t_drive_item want;
        if (!i_rst_n) begin
            tick_cnt = '0;
            tube_idx = '0;
            words_due.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_tick(i_s_axis_tdata, i_s_axis_tuser);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (words_due.size() == 0) begin
                    $error("unexpected output item: drive_word %h, last_of_tick %b",
                           i_m_axis_tdata, i_m_axis_tlast);
                    fail_cnt++;
                end else begin
                    want = words_due.pop_front();
                    checked_cnt++;
                    if (i_m_axis_tdata !== want.word) begin
                        $error("drive_word: expected %h, actual %h",
                               want.word, i_m_axis_tdata);
                        fail_cnt++;
                    end
                    if (i_m_axis_tlast !== want.last) begin
                        $error("last_of_tick: expected %b, actual %b",
                               want.last, i_m_axis_tlast);
                        fail_cnt++;
                    end
                end
            end
        end
        o_fail_count    = fail_cnt;
        o_words_due     = words_due.size();
        o_words_checked = checked_cnt;
    end

endmodule

/* tb/nixie_mux_scan_driver_core_tb.sv */
// ----------------------------------------------------------------------------
// Nixie scan driver core testbench
// Feeds scan ticks to the scan driver core: a directed opening that walks every
// tube through digit, dot, separator and mode corners, then random ticks with
// random pacing on both stream sides and one long output hold-off. A separate
// checker predicts and compares every output item.
// ----------------------------------------------------------------------------
module nixie_mux_scan_driver_core_tb;

    localparam int TUBES        = nixie_pkg::TUBE_COUNT_DEF;
    localparam int RANDOM_TICKS = 950;
    // The tail of the random part runs with both sides always ready.
    localparam int CALM_TICKS   = 120;
    // Ticks after which the sink holds off, and for how long.
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 200;
    // A lit tick's blanking word leaves after its drive word;
    // the drain wait after the last expected item is a comfortable margin.
    localparam int DRAIN_CYCLES = 16;
    // Worst case is about 1000 ticks, each lit, each of its two items waiting
    // out the longest sink stall, plus sender gaps and the hold-off; this is several
    // times that.
    localparam int CYCLE_LIMIT  = 200000;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // brightness[7:0], first_pair[14:8], second_pair[21:15], third_pair[28:22],
    // digit_enable[34:29], dot_mask[42:35], zero fill [47:43].
    logic [nixie_pkg::IN_DATA_W-1:0] s_axis_tdata  = '0;
    // time_mode[0], date_edit[1].
    logic [nixie_pkg::IN_USER_W-1:0] s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // drive_word[31:0].
    logic [nixie_pkg::WORD_W-1:0]    m_axis_tdata;
    // last_of_tick.
    logic                            m_axis_tlast;

    int fail_count;
    int words_due;
    int words_checked;
    int ticks_sent = 0;
    int cycle_cnt  = 0;

    // Pacing controls shared between the source and the sink processes.
    bit src_gaps_on  = 1'b1;
    bit sink_gaps_on = 1'b1;
    bit hold_req     = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    nixie_mux_scan_driver_core #(
        .TUBE_COUNT (TUBES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    nixie_scan_checker #(
        .TUBE_COUNT (TUBES)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_words_due     (words_due),
        .o_words_checked (words_checked)
    );

    // Watchdog: a hung handshake or a missing output item ends here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d items outstanding.",
                     cycle_cnt, words_due);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offers one scan tick and holds it until the block takes it. Valid is
    // only lowered when a gap follows, so back-to-back ticks keep it high.
    task automatic send_tick(input logic [7:0] bri, input logic [6:0] p1,
                             input logic [6:0] p2, input logic [6:0] p3,
                             input logic [5:0] en, input logic [7:0] dots,
                             input logic tm, input logic de);
        int gap;
        s_axis_tdata  <= {5'd0, dots, en, p3, p2, p1, bri};
        s_axis_tuser  <= {de, tm};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_sent++;
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Two-digit value: mostly a real clock value, sometimes above 99 so that
    // the upper bits of the field and the tens wrap get exercised.
    function automatic logic [6:0] rand_pair();
        if ($urandom_range(0, 7) == 0) begin
            return 7'($urandom_range(100, 127));
        end
        return 7'($urandom_range(0, 99));
    endfunction

    task automatic send_random_tick(input bit full_bright);
        logic [7:0] bri;
        case ($urandom_range(0, 9)) inside
            0:       bri = 8'd0;
            1, 2:    bri = 8'd255;
            3:       bri = 8'($urandom_range(0, 15));
            default: bri = 8'($urandom_range(0, 255));
        endcase
        if (full_bright) begin
            bri = 8'd255;
        end
        send_tick(bri, rand_pair(), rand_pair(), rand_pair(),
                  6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Sink pacing: ready runs, random stall bursts, and the single long
    // hold-off that lets the block's queue fill and back-pressure the source.
    initial begin : sink_pacing
        int held;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
            end else if (sink_gaps_on && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Dark ticks: zero brightness, and a brightness of one that the
        // counter has already passed.
        send_tick(8'd0, 7'd99, 7'd99, 7'd99, 6'h3F, 8'hFF, 1'b1, 1'b1);
        send_tick(8'd1, 7'd12, 7'd34, 7'd56, 6'h3F, 8'hFF, 1'b0, 1'b0);

        // Full scan with every tube enabled, every dot lit, values at both
        // ends of the range and one above 99 on the rightmost pair.
        for (k = 0; k < TUBES; k++) begin
            send_tick(8'd255, 7'd99, 7'd0, 7'd127, 6'h3F, 8'hFF, 1'b0, 1'b0);
        end
        // Every tube disabled so only dots and separators remain; both mode
        // flags with odd seconds, so separators come on and then lose their
        // lower bits.
        for (k = 0; k < TUBES; k++) begin
            send_tick(8'd255, 7'd10, 7'd45, 7'd35, 6'h00, 8'h00, 1'b1, 1'b1);
        end
        // Time mode alone on even seconds clears separators the mask asked
        // for; alternate tubes enabled and alternate dots.
        for (k = 0; k < TUBES; k++) begin
            send_tick(8'd255, 7'd127, 7'd99, 7'd64, 6'h2A, 8'hD5, 1'b1, 1'b0);
        end

        for (k = 0; k < RANDOM_TICKS; k++) begin
            if (k >= RANDOM_TICKS - CALM_TICKS) begin
                src_gaps_on  = 1'b0;
                sink_gaps_on = 1'b0;
            end else if (k % 100 == 0) begin
                // Each stretch picks its own pacing, some with no idling.
                src_gaps_on  = ($urandom_range(0, 3) != 0);
                sink_gaps_on = ($urandom_range(0, 3) != 0);
            end
            if (k == HOLD_AT) begin
                hold_req = 1'b1;
            end
            // Keep ticks lit around the hold-off so that output items pile up.
            send_random_tick(k >= HOLD_AT && k < HOLD_AT + 24);
        end
        s_axis_tvalid <= 1'b0;

        while (words_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Scan run: %0d ticks driven, %0d output items compared.",
                 ticks_sent, words_checked);
        $display("Pacing: random stalls on both sides and one %0d-cycle sink hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
